>>> sv/bc7pr_pkg.sv
// Package for the BC7 palette ramp generator: request/result structs,
// pipeline stage struct, weight tables and the endpoint expansion function.
// No dependencies.
package bc7pr_pkg;

  localparam int NumChan   = 4;
  localparam int ChanW     = 8;
  localparam int WeightW   = 7;
  localparam int IdxW      = 4;
  localparam int PrecW     = 3;
  localparam int ProdW     = WeightW + ChanW;
  localparam int SumW      = ProdW + 1;

  localparam logic [PrecW-1:0] MaxPrec    = 3'd4;
  localparam logic [3:0]       MaxChanBits = 4'd8;
  localparam logic [WeightW-1:0] WeightOne = 7'd64;
  localparam logic [SumW-1:0]  RoundBias  = 16'd32;
  localparam int               WeightShift = 6;

  localparam logic [WeightW-1:0] Wt1 [2]  = '{7'd0, 7'd64};
  localparam logic [WeightW-1:0] Wt2 [4]  = '{7'd0, 7'd21, 7'd43, 7'd64};
  localparam logic [WeightW-1:0] Wt3 [8]  = '{7'd0, 7'd9, 7'd18, 7'd27,
                                              7'd37, 7'd46, 7'd55, 7'd64};
  localparam logic [WeightW-1:0] Wt4 [16] = '{7'd0, 7'd4, 7'd9, 7'd13,
                                              7'd17, 7'd21, 7'd26, 7'd30,
                                              7'd34, 7'd38, 7'd43, 7'd47,
                                              7'd51, 7'd55, 7'd60, 7'd64};

  typedef logic [NumChan-1:0][ChanW-1:0] rgba_t;

  // Input request: one block's endpoints and precisions
  typedef struct packed {
    logic [31:0] endpoint_low;
    logic [31:0] endpoint_high;
    logic [3:0]  red_bits;
    logic [3:0]  green_bits;
    logic [3:0]  blue_bits;
    logic [3:0]  alpha_bits;
    logic [2:0]  color_index_bits;
    logic [2:0]  alpha_index_bits;
  } in_req_t;

  // One palette entry
  typedef struct packed {
    logic [3:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       color_valid;
    logic       alpha_valid;
    logic       last;
  } out_res_t;

  // Entry issued by the sequencer into the interpolator pipeline
  typedef struct packed {
    logic               valid;
    logic [IdxW-1:0]    idx;
    logic [WeightW-1:0] cw;
    logic [WeightW-1:0] aw;
    logic               cv;
    logic               av;
    logic               last;
    rgba_t              e0;
    rgba_t              e1;
  } issue_t;

  // Expand a stored channel to 8 bits with bit replication, clamp at 255
  function automatic logic [ChanW-1:0] expand_chan(input logic [ChanW-1:0] v,
                                                   input logic [3:0] bits);
    logic [3:0]  b;
    logic [15:0] s;
    b = (bits > MaxChanBits) ? MaxChanBits : bits;
    s = 16'(v) << (MaxChanBits - b);
    s = s + (s >> b);
    if (bits == 4'd0) begin
      expand_chan = '0;
    end else if (s > 16'd255) begin
      expand_chan = 8'hff;
    end else begin
      expand_chan = s[ChanW-1:0];
    end
  endfunction

  // BC7 interpolation weight for a ramp of 2^prec entries
  function automatic logic [WeightW-1:0] weight_of(input logic [PrecW-1:0] prec,
                                                   input logic [IdxW-1:0] idx);
    case (prec)
      3'd0:    weight_of = '0;
      3'd1:    weight_of = Wt1[idx[0]];
      3'd2:    weight_of = Wt2[idx[1:0]];
      3'd3:    weight_of = Wt3[idx[2:0]];
      default: weight_of = Wt4[idx];
    endcase
  endfunction

endpackage

>>> sv/bc7pr_expand.sv
// Endpoint expansion: widens both RGBA endpoints to 8 bits per channel.
// Depends on bc7pr_pkg.
module bc7pr_expand (
  input  bc7pr_pkg::in_req_t req,
  output bc7pr_pkg::rgba_t   e0,
  output bc7pr_pkg::rgba_t   e1
);
  import bc7pr_pkg::*;

  logic [NumChan-1:0][3:0] bits;

  assign bits = {req.alpha_bits, req.blue_bits, req.green_bits, req.red_bits};

  // Per-channel expansion; absent alpha reads as opaque
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      e0[c] = expand_chan(req.endpoint_low[8*c +: 8], bits[c]);
      e1[c] = expand_chan(req.endpoint_high[8*c +: 8], bits[c]);
    end
    if (req.alpha_bits == 4'd0) begin
      e0[NumChan-1] = 8'hff;
      e1[NumChan-1] = 8'hff;
    end
  end

endmodule

>>> sv/bc7pr_seq.sv
// Entry sequencer: holds one block and issues one palette entry per cycle
// with its weights and flags into the interpolator. Depends on bc7pr_pkg.
module bc7pr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  bc7pr_pkg::in_req_t req,
  input  bc7pr_pkg::rgba_t  e0_in,
  input  bc7pr_pkg::rgba_t  e1_in,
  output logic              busy,
  output bc7pr_pkg::issue_t iss
);
  import bc7pr_pkg::*;

  logic [PrecW-1:0] cprec, aprec;
  logic [IdxW:0]    clen, alen, nlen;

  rgba_t            e0_r, e1_r;
  logic [PrecW-1:0] cprec_r, aprec_r;
  logic [IdxW-1:0]  last_idx_r;
  logic [IdxW-1:0]  cnt_r, cnt_nxt;
  logic             active_r, active_nxt;
  issue_t           iss_r, iss_nxt;

  // Ramp lengths from clamped index widths
  assign cprec = (req.color_index_bits > MaxPrec) ? MaxPrec : req.color_index_bits;
  assign aprec = (req.alpha_index_bits > MaxPrec) ? MaxPrec : req.alpha_index_bits;
  assign clen  = (IdxW+1)'(1) << cprec;
  assign alen  = (IdxW+1)'(1) << aprec;
  assign nlen  = (clen > alen) ? clen : alen;

  // Counter control
  always_comb begin
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    if (accept) begin
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == last_idx_r) begin
        active_nxt = 1'b0;
      end
    end
  end

  // Issue stage contents
  always_comb begin
    iss_nxt.valid = active_r;
    iss_nxt.idx   = cnt_r;
    iss_nxt.cw    = weight_of(cprec_r, cnt_r);
    iss_nxt.aw    = weight_of(aprec_r, cnt_r);
    iss_nxt.cv    = {1'b0, cnt_r} < ((IdxW+1)'(1) << cprec_r);
    iss_nxt.av    = {1'b0, cnt_r} < ((IdxW+1)'(1) << aprec_r);
    iss_nxt.last  = (cnt_r == last_idx_r);
    iss_nxt.e0    = e0_r;
    iss_nxt.e1    = e1_r;
  end

  // Block hold registers
  always_ff @(posedge clk) begin
    if (accept) begin
      e0_r       <= e0_in;
      e1_r       <= e1_in;
      cprec_r    <= cprec;
      aprec_r    <= aprec;
      last_idx_r <= IdxW'(nlen - 1'b1);
    end
  end

  // Control and issue registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      iss_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      iss_r    <= iss_nxt;
    end
  end

  assign busy = active_r;
  assign iss  = iss_r;

endmodule

>>> sv/bc7pr_lerp.sv
// Interpolator pipeline: weighted products in one stage, round, shift and
// range masking in the next, into the result register. Depends on bc7pr_pkg.
module bc7pr_lerp (
  input  logic                clk,
  input  logic                rst_n,
  input  bc7pr_pkg::issue_t   iss,
  output logic                res_valid,
  output bc7pr_pkg::out_res_t res
);
  import bc7pr_pkg::*;

  logic [NumChan-1:0][ProdW-1:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic                          v2_r;
  logic [IdxW-1:0]               idx2_r;
  logic                          cv2_r, av2_r, last2_r;
  logic [NumChan-1:0][ChanW-1:0] lerp;
  logic                          res_valid_r;
  out_res_t                      res_r, res_nxt;

  // Products: channels 0..2 use the colour weight, alpha its own
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      logic [WeightW-1:0] w;
      w = (c == NumChan-1) ? iss.aw : iss.cw;
      p0_nxt[c] = ProdW'(WeightOne - w) * ProdW'(iss.e0[c]);
      p1_nxt[c] = ProdW'(w) * ProdW'(iss.e1[c]);
    end
  end

  // Rounded sum and output formatting
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      logic [SumW-1:0] s;
      s = SumW'(p0_r[c]) + SumW'(p1_r[c]) + RoundBias;
      lerp[c] = s[WeightShift +: ChanW];
    end
    res_nxt.entry_index = idx2_r;
    res_nxt.red         = cv2_r ? lerp[0] : '0;
    res_nxt.green       = cv2_r ? lerp[1] : '0;
    res_nxt.blue        = cv2_r ? lerp[2] : '0;
    res_nxt.alpha       = av2_r ? lerp[3] : '0;
    res_nxt.color_valid = cv2_r;
    res_nxt.alpha_valid = av2_r;
    res_nxt.last        = last2_r;
  end

  // Stage payload
  always_ff @(posedge clk) begin
    p0_r    <= p0_nxt;
    p1_r    <= p1_nxt;
    idx2_r  <= iss.idx;
    cv2_r   <= iss.cv;
    av2_r   <= iss.av;
    last2_r <= iss.last;
    res_r   <= res_nxt;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      v2_r        <= iss.valid;
      res_valid_r <= v2_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> sv/bc7_palette_ramp_generator.sv
// Top level of the BC7 palette ramp generator: expansion, sequencer and
// interpolator pipeline. Depends on bc7pr_pkg, bc7pr_expand, bc7pr_seq, bc7pr_lerp.
//
//   channel  ports                      direction  taken when
//   request  start, busy, in_req        in         start & !busy
//   result   out_valid, out_res         out        every cycle out_valid is high
//
// A request keeps busy high while the sequencer issues max(2^color, 2^alpha)
// palette entries (1 to 16), one per cycle, into the shared interpolator.
// Entries pass the counter, issue, product and result registers to out_res; the
// next request may be taken in the cycle busy falls while earlier entries drain.
// Synchronous active-low reset clears the sequencer and all stage valid bits.
// Results are strobed for one cycle each; the receiver cannot stall.
module bc7_palette_ramp_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bc7pr_pkg::in_req_t  in_req,
  output logic                out_valid,
  output bc7pr_pkg::out_res_t out_res
);
  import bc7pr_pkg::*;

  rgba_t  e0, e1;
  issue_t iss;
  logic   accept;

  assign accept = start & ~busy;

  bc7pr_expand u_expand (
    .req (in_req),
    .e0  (e0),
    .e1  (e1)
  );

  bc7pr_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_req),
    .e0_in  (e0),
    .e1_in  (e1),
    .busy   (busy),
    .iss    (iss)
  );

  bc7pr_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss       (iss),
    .res_valid (out_valid),
    .res       (out_res)
  );

  // A taken request always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request taken but sequencer idle");

  // Entries of one block come back to back with rising index
  a_entry_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |=>
      (out_valid && out_res.entry_index == $past(out_res.entry_index) + 4'd1))
    else $error("gap or skip inside a palette run");

  // After the final entry the next entry starts a new block
  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |=> (!out_valid || out_res.entry_index == 4'd0))
    else $error("new palette run does not start at entry zero");

  // Colour outside its ramp reads as zero
  a_color_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.color_valid) |->
      (out_res.red == 8'd0 && out_res.green == 8'd0 && out_res.blue == 8'd0))
    else $error("colour not masked outside ramp");

endmodule
